// ===== src/fsmp_pkg.sv =====
// Shared types and constants for the framed status message parser.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package fsmp_pkg;

  // Longest payload a frame may carry before it counts as an overflow.
  localparam int MAX_PAYLOAD   = 16;
  localparam int KEPT_BYTES    = 5;
  localparam int CHAIRS        = 4;
  localparam int COUNT_W       = 5;
  localparam int KEPT_IDX_W    = $clog2(KEPT_BYTES);
  localparam int LEVEL_W       = 10;
  localparam int TEMP_MIN_LEN  = 2;
  localparam int SWEEP_MIN_LEN = CHAIRS + 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(4);

  // Input kind carried on tuser.
  localparam logic REQ_GAP = 1'b1;

  typedef enum logic [1:0] {
    ST_TEMP  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_START     = 2'd0,
    CFG_END       = 2'd1,
    CFG_TEMP_TAG  = 2'd2,
    CFG_SWEEP_TAG = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] temperature_tag;
    logic [7:0] sweep_tag;
  } cfg_t;

  // One decoded frame: outcome and payload bytes 1..4.
  typedef struct packed {
    status_t                status;
    logic [CHAIRS-1:0][7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/fsmp_front.sv =====
// Front end: frame hunting, payload capture and frame classification.
// Depends on fsmp_pkg; pushes one command per finished or failed frame.
`default_nettype none

module fsmp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fsmp_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic          req_type,
  input  wire logic [7:0]    rx_byte,
  output logic               push,
  output fsmp_pkg::cmd_t     push_cmd
);
  import fsmp_pkg::*;

  logic                     in_frame;
  logic [COUNT_W-1:0]       payload_count;
  logic [KEPT_BYTES-1:0][7:0] captured_bytes;

  logic    is_gap;
  logic    is_end;
  logic    is_full;
  status_t decoded;

  assign is_gap  = (req_type == REQ_GAP);
  assign is_end  = (rx_byte == cfg.end_marker);
  assign is_full = (payload_count >= COUNT_W'(MAX_PAYLOAD));

  always_comb begin
    priority if (payload_count == '0) begin
      decoded = ST_ERROR;
    end else if (captured_bytes[0] == cfg.temperature_tag) begin
      decoded = (payload_count >= COUNT_W'(TEMP_MIN_LEN)) ? ST_TEMP : ST_ERROR;
    end else if (captured_bytes[0] == cfg.sweep_tag) begin
      decoded = (payload_count >= COUNT_W'(SWEEP_MIN_LEN)) ? ST_SWEEP : ST_ERROR;
    end else begin
      decoded = ST_ERROR;
    end
  end

  assign push = accept && in_frame && (is_gap || is_end || is_full);

  always_comb begin
    push_cmd.status = (is_gap || !is_end) ? ST_ERROR : decoded;
    for (int i = 0; i < CHAIRS; i++) begin
      push_cmd.data[i] = captured_bytes[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      payload_count <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (!is_gap && rx_byte == cfg.start_marker) begin
          in_frame      <= 1'b1;
          payload_count <= '0;
        end
      end else if (is_gap || is_end || is_full) begin
        in_frame      <= 1'b0;
        payload_count <= '0;
      end else begin
        payload_count <= payload_count + COUNT_W'(1);
      end
    end
  end

  // Payload store: only the first few bytes are kept.
  always_ff @(posedge clk) begin
    if (accept && in_frame && !is_gap && !is_end && !is_full) begin
      for (int i = 0; i < KEPT_BYTES; i++) begin
        if (payload_count == COUNT_W'(i)) begin
          captured_bytes[i] <= rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/fsmp_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on fsmp_pkg for the command type and depth.
`default_nettype none

module fsmp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fsmp_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output fsmp_pkg::cmd_t      head
);
  import fsmp_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/fsmp_back.sv =====
// Back end: applies decoded frames to the stored values and drives results.
// Depends on fsmp_pkg; the stored values are the result payload.
`default_nettype none

module fsmp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire fsmp_pkg::cmd_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fsmp_pkg::status_t   out_status,
  output logic [7:0]          temperature,
  output logic [7:0]          previous_temperature,
  output logic [fsmp_pkg::CHAIRS-1:0][fsmp_pkg::LEVEL_W-1:0] chair_levels
);
  import fsmp_pkg::*;

  // Stored values only change on a pop, so a held result stays stable.
  assign pop = !empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid            <= 1'b0;
      out_status           <= ST_ERROR;
      temperature          <= '0;
      previous_temperature <= '0;
      for (int i = 0; i < CHAIRS; i++) begin
        chair_levels[i] <= LEVEL_RESET;
      end
    end else begin
      if (pop) begin
        out_valid  <= 1'b1;
        out_status <= head.status;
        unique case (head.status)
          ST_TEMP: begin
            previous_temperature <= temperature;
            temperature          <= head.data[0];
          end
          ST_SWEEP: begin
            for (int i = 0; i < CHAIRS; i++) begin
              chair_levels[i] <= LEVEL_W'({head.data[i], 2'b00});
            end
          end
          default: begin
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/framed_status_message_parser.sv =====
// Top level of the framed status message parser: config registers and wiring.
// Depends on fsmp_pkg, fsmp_front, fsmp_queue and fsmp_back.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready   | tdata: rx_byte; tuser: req_type
//  m_      | out | m_tvalid / m_tready   | tdata: temperature .. chair_level_3;
//          |     |                       | tuser: status
//  cfg_    | in  | cfg_we (no wait)      | cfg_index, cfg_data
//
// One input beat per cycle is taken whenever the command queue has room.
// The beat that closes or breaks a frame pushes a command into the queue as
// it is taken; the back end then registers the result. Throughput is one
// result per cycle while m_tready is high, set by the single output register.
// The queue (two entries) absorbs output stalls; s_tready drops only when it
// is full. Reset is synchronous: hunting, temperatures 0, chair levels 4.
`default_nettype none

module framed_status_message_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] req_type (1 = gap)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [7:0] temperature, [15:8] previous_temperature,
                                      // [25:16] chair_level_0, [35:26] chair_level_1,
                                      // [45:36] chair_level_2, [55:46] chair_level_3
  output logic [1:0]       m_tuser,   // [1:0] status
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import fsmp_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    q_empty;
  cmd_t    q_head;
  logic    pop;
  status_t out_status;
  logic [7:0] temperature;
  logic [7:0] previous_temperature;
  logic [CHAIRS-1:0][LEVEL_W-1:0] chair_levels;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker    <= 8'd2;
      cfg.end_marker      <= 8'd3;
      cfg.temperature_tag <= 8'd84;
      cfg.sweep_tag       <= 8'd83;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START:     cfg.start_marker    <= cfg_data;
        CFG_END:       cfg.end_marker      <= cfg_data;
        CFG_TEMP_TAG:  cfg.temperature_tag <= cfg_data;
        CFG_SWEEP_TAG: cfg.sweep_tag       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Accept a beat whenever the queue can take a command it might cause.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  fsmp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .req_type (s_tuser),
    .rx_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd)
  );

  fsmp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  fsmp_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .empty                (q_empty),
    .head                 (q_head),
    .pop                  (pop),
    .out_valid            (m_tvalid),
    .out_ready            (m_tready),
    .out_status           (out_status),
    .temperature          (temperature),
    .previous_temperature (previous_temperature),
    .chair_levels         (chair_levels)
  );

  // Pack the result beat, first field in the low bits.
  assign m_tuser = out_status;
  assign m_tdata = {chair_levels[3], chair_levels[2], chair_levels[1], chair_levels[0],
                    previous_temperature, temperature};

endmodule

`default_nettype wire

// ===== src/fsmp_checker.sv =====
// Port-level checker for the framed status message parser, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module fsmp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // No result may be presented right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // Stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // Status takes only the three defined codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined status code");

  // Chair levels are always multiples of four.
  a_levels: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:16] == 2'b00 && m_tdata[27:26] == 2'b00 &&
                 m_tdata[37:36] == 2'b00 && m_tdata[47:46] == 2'b00)
    else $error("chair level not a multiple of four");

endmodule

bind framed_status_message_parser fsmp_checker u_fsmp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for framed_status_message_parser: stream driver, monitor
// and a cycle-free predictor of frame decoding. Depends on fsmp_pkg and the RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsmp_pkg::*;

  // One input beat as the bench queues it: gap flag (tuser) and byte (tdata).
  typedef struct packed {
    logic       gap;
    logic [7:0] rx;
  } rx_item_t;

  // One decoded status report, field by field as the block emits it.
  typedef struct packed {
    status_t                         status;
    logic [7:0]                      temp;
    logic [7:0]                      prev_temp;
    logic [CHAIRS-1:0][LEVEL_W-1:0]  level;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;

  framed_status_message_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: marker/tag settings plus the parser's own copy of framing,
  // held payload, temperatures and chair levels.
  // ---------------------------------------------------------------------------
  cfg_t                           marks = '{8'd2, 8'd3, 8'd84, 8'd83};
  logic                           framing = 1'b0;
  logic [COUNT_W-1:0]             held_count = '0;
  logic [7:0]                     held_bytes [KEPT_BYTES];
  logic [7:0]                     temp_now = 8'd0;
  logic [7:0]                     temp_before = 8'd0;
  logic [CHAIRS-1:0][LEVEL_W-1:0] chair_lvl = {CHAIRS{LEVEL_RESET}};

  rx_item_t rx_items [$];         // beats waiting to be offered
  report_t  pending_reports [$];  // reports the block still owes us
  int       errors = 0;

  // Knobs the stimulus process sets per phase.
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  bit holdoff_armed = 1'b0;

  // Decode a closed frame by its tag; update stored values on success.
  function automatic status_t close_frame();
    if (held_count == 0)
      return ST_ERROR;
    // Temperature tag wins when both tags are equal.
    if (held_bytes[0] == marks.temperature_tag) begin
      if (held_count < TEMP_MIN_LEN)
        return ST_ERROR;
      temp_before = temp_now;
      temp_now    = held_bytes[1];
      return ST_TEMP;
    end
    if (held_bytes[0] == marks.sweep_tag) begin
      if (held_count < SWEEP_MIN_LEN)
        return ST_ERROR;
      for (int i = 0; i < CHAIRS; i++)
        chair_lvl[i] = {held_bytes[i+1], 2'b00};
      return ST_SWEEP;
    end
    return ST_ERROR;
  endfunction

  // Advance the predictor by one accepted beat; queue a report if one is due.
  task automatic parse_beat(logic gap, logic [7:0] b);
    bit      due;
    status_t st;
    report_t rep;
    due = 1'b0;
    st  = ST_ERROR;
    if (!framing) begin
      // Hunting: drop everything except the start marker.
      if (!gap && b == marks.start_marker) begin
        framing    = 1'b1;
        held_count = '0;
      end
    end else if (gap) begin
      due = 1'b1;
    end else if (b == marks.end_marker) begin
      // End marker is checked before the payload limit, so it always closes the frame.
      st  = close_frame();
      due = 1'b1;
    end else if (held_count >= MAX_PAYLOAD) begin
      due = 1'b1;
    end else begin
      if (held_count < KEPT_BYTES)
        held_bytes[held_count] = b;
      held_count = held_count + 1'b1;
    end
    if (due) begin
      framing        = 1'b0;
      held_count     = '0;
      rep.status     = st;
      rep.temp       = temp_now;
      rep.prev_temp  = temp_before;
      rep.level      = chair_lvl;
      pending_reports.push_back(rep);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued beats, predict on each accepted beat, idle at random.
  // ---------------------------------------------------------------------------
  rx_item_t cur_item = '0;
  bit       offering = 1'b0;
  int       src_wait = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_beat(cur_item.gap, cur_item.rx);
        offering = 1'b0;
        src_wait = src_idle_on ? $urandom_range(0, 6) : 0;
      end
      // Hold the current beat until taken; otherwise count down, then load.
      if (!offering) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (rx_items.size() > 0) begin
          cur_item = rx_items.pop_front();
          offering = 1'b1;
        end
      end
      s_tvalid <= offering;
      s_tdata  <= cur_item.rx;
      s_tuser  <= cur_item.gap;
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here once armed, so the command queue
  // fills up and s_tready has to drop.
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  bit   holdoff_done = 1'b0;
  logic sink_hold = 1'b0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (holdoff_armed && !holdoff_done) begin
      hold_left    = 400;
      holdoff_done = 1'b1;
    end
    sink_hold <= (hold_left > 0);
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted report with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  report_t exp_rep;
  int      sink_wait = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report: status %0d, tdata %h", m_tuser, m_tdata);
          errors++;
        end else begin
          exp_rep = pending_reports.pop_front();
          check_field("status", exp_rep.status, m_tuser);
          check_field("temperature", exp_rep.temp, m_tdata[7:0]);
          check_field("previous_temperature", exp_rep.prev_temp, m_tdata[15:8]);
          for (int i = 0; i < CHAIRS; i++)
            check_field($sformatf("chair_level_%0d", i), exp_rep.level[i],
                        m_tdata[16 + LEVEL_W*i +: LEVEL_W]);
        end
        sink_wait = snk_idle_on ? $urandom_range(0, 6) : 0;
      end else if (m_tvalid && sink_wait > 0) begin
        // Stall only while a report is actually waiting.
        sink_wait--;
      end
      m_tready <= (sink_wait == 0) && !sink_hold;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic gap, logic [7:0] b);
    rx_items.push_back('{gap, b});
  endtask

  task automatic push_gap();
    push_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Random payload byte that does not close the frame early.
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == marks.end_marker)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Random byte that keeps a hunting parser hunting.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == marks.start_marker)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Write one register while the block is idle; the predictor follows.
  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_START:     marks.start_marker    = val;
      CFG_END:       marks.end_marker      = val;
      CFG_TEMP_TAG:  marks.temperature_tag = val;
      CFG_SWEEP_TAG: marks.sweep_tag       = val;
      default: ;
    endcase
  endtask

  task automatic set_markers(logic [7:0] st, logic [7:0] en, logic [7:0] tt,
                             logic [7:0] sw);
    write_reg(CFG_START, st);
    write_reg(CFG_END, en);
    write_reg(CFG_TEMP_TAG, tt);
    write_reg(CFG_SWEEP_TAG, sw);
    cfg_we <= 1'b0;
  endtask

  // Wait until every beat is taken and every report is in, then let the
  // pipeline settle.
  task automatic wait_idle();
    while (rx_items.size() > 0 || offering || pending_reports.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise.
  task automatic random_traffic(int n_items);
    int         target;
    int         kind;
    int         extra;
    int         pick;
    logic [7:0] tag;
    target = rx_items.size() + n_items;
    while (rx_items.size() < target) begin
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      tag  = (pick < 45) ? marks.temperature_tag :
             (pick < 90) ? marks.sweep_tag : 8'($urandom_range(0, 255));
      if (kind < 60) begin
        // Well-formed frame, length around what the tag needs.
        extra = (tag == marks.temperature_tag) ? $urandom_range(1, 4) :
                (tag == marks.sweep_tag) ? $urandom_range(4, 8) : $urandom_range(0, 5);
        push_beat(1'b0, marks.start_marker);
        push_beat(1'b0, tag);
        repeat (extra) push_beat(1'b0, payload_byte());
        push_beat(1'b0, marks.end_marker);
      end else if (kind < 70) begin
        // Short or empty frame.
        push_beat(1'b0, marks.start_marker);
        extra = $urandom_range(0, 4);
        if (extra > 0)
          push_beat(1'b0, tag);
        repeat (extra - (extra > 0)) push_beat(1'b0, payload_byte());
        push_beat(1'b0, marks.end_marker);
      end else if (kind < 78) begin
        // Gap breaks a frame somewhere inside.
        push_beat(1'b0, marks.start_marker);
        repeat ($urandom_range(0, 6)) push_beat(1'b0, payload_byte());
        push_gap();
      end else if (kind < 85) begin
        // Around the payload limit: fits, fills exactly, or overflows.
        push_beat(1'b0, marks.start_marker);
        repeat (MAX_PAYLOAD - 1 + $urandom_range(0, 3)) push_beat(1'b0, payload_byte());
        push_beat(1'b0, marks.end_marker);
      end else begin
        // Line noise while hunting: stray bytes and gaps.
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0)
            push_gap();
          else
            push_beat(1'b0, noise_byte());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, then phases of settings, each ended by a drain.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 0: reset-value markers, then the directed cases.
    set_markers(8'd2, 8'd3, 8'd84, 8'd83);
    push_gap();                                        // gap while hunting
    push_beat(1'b0, 8'hFF);                            // stray byte while hunting
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'd3);      // empty frame
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'd84);     // temperature, max value
    push_beat(1'b0, 8'hFF); push_beat(1'b0, 8'd3);
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'd83);     // sweep, level extremes,
    push_beat(1'b0, 8'h00); push_beat(1'b0, 8'hFF);    // start marker as payload
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'h01);
    push_beat(1'b0, 8'd3);
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'd84);     // short temperature frame
    push_beat(1'b0, 8'd3);
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'd83);     // short sweep frame
    push_beat(1'b0, 8'h10); push_beat(1'b0, 8'd3);
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'h00);     // unknown tag
    push_beat(1'b0, 8'd3);
    push_beat(1'b0, 8'd2); push_beat(1'b0, 8'd84);     // gap inside a frame
    push_gap();
    random_traffic(255);
    wait_idle();

    // Phase 1: equal tags and low/high markers, plus a payload overflow.
    set_markers(8'h00, 8'hFF, 8'h55, 8'h55);
    push_beat(1'b0, 8'h00); push_beat(1'b0, 8'h55);    // equal tags: temperature
    repeat (4) push_beat(1'b0, payload_byte());
    push_beat(1'b0, 8'hFF);
    push_beat(1'b0, 8'h00);                            // one byte past the limit
    repeat (MAX_PAYLOAD + 1) push_beat(1'b0, payload_byte());
    push_beat(1'b0, 8'hFF);
    random_traffic(255);
    wait_idle();

    // Phase 2: opposite extremes, no idling on either side.
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_markers(8'hFF, 8'h00, 8'h00, 8'hFF);
    random_traffic(255);
    wait_idle();

    // Phase 3: flat-out sender against a long receiver hold-off.
    snk_idle_on = 1'b1;
    set_markers(8'h7E, 8'h7F, 8'hFF, 8'h00);
    random_traffic(255);
    holdoff_armed = 1'b1;
    wait_idle();

    // Phases 4 and 5: random settings, idling on one or both sides.
    src_idle_on = 1'b1;
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(255);
    wait_idle();

    snk_idle_on = 1'b0;
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(255);
    wait_idle();

    // Phase 6: start and end markers equal.
    snk_idle_on = 1'b1;
    set_markers(8'h5A, 8'h5A, 8'h01, 8'h02);
    random_traffic(255);
    wait_idle();

    if (errors == 0 && pending_reports.size() == 0) begin
      $display("** framed_status_message_parser: PASSED **");
    end else begin
      $display("** framed_status_message_parser: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("** framed_status_message_parser: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== framed_status_message_parser.f =====
src/fsmp_pkg.sv
src/fsmp_front.sv
src/fsmp_queue.sv
src/fsmp_back.sv
src/framed_status_message_parser.sv
src/fsmp_checker.sv
tb/sv/tb.sv
